// File: design/kdts_pkg.sv
// Shared constants, op codes and controller/datapath interface types for the kd-tree search.
package kdts_pkg;

	localparam int NODE_COUNT_DEF = 1024;
	localparam int COORD_W_DEF    = 24;
	localparam int DIST_W         = 24;
	localparam int OP_W           = 2;

	// 3000.0 in unsigned Q16.8
	localparam logic [DIST_W-1:0] BOUND_RESET = 24'd768000;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic write_node;
		logic clear_tree;
		logic start_query;
		logic rd_node;
		logic eval_diff;
		logic eval_sum;
		logic eval_best;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic root_present;
		logic next_valid;
	} sts_t;

endpackage

// File: design/kdts_ctrl.sv
// Sequencer for node writes, tree clear and the per-level query walk.
module kdts_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [kdts_pkg::OP_W-1:0]  op,
	output logic                       in_ready,
	output logic                       out_valid,
	input  logic                       out_ready,
	input  kdts_pkg::sts_t             sts,
	output kdts_pkg::cmd_t             cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_DIFF = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_BEST = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (op)
						kdts_pkg::OP_WRITE: cmd.write_node = 1'b1;
						kdts_pkg::OP_CLEAR: cmd.clear_tree = 1'b1;
						kdts_pkg::OP_QUERY: begin
							cmd.start_query = 1'b1;
							state_d = sts.root_present ? S_READ : S_DONE;
						end
						default: ;
					endcase
				end
			end
			S_READ: begin
				cmd.rd_node = 1'b1;
				state_d = S_DIFF;
			end
			S_DIFF: begin
				cmd.eval_diff = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.eval_sum = 1'b1;
				state_d = S_BEST;
			end
			S_BEST: begin
				cmd.eval_best = 1'b1;
				state_d = sts.next_valid ? S_READ : S_DONE;
			end
			S_DONE: begin
				// hold until the output register can take the beat
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/kdts_dp.sv
// Node table memory, query registers, distance arithmetic and result register.
module kdts_dp #(
	parameter int NODE_COUNT  = kdts_pkg::NODE_COUNT_DEF,
	parameter int COORD_WIDTH = kdts_pkg::COORD_W_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kdts_pkg::cmd_t                    cmd,
	output kdts_pkg::sts_t                    sts,
	input  logic                              cfg_wr_en,
	input  logic [kdts_pkg::DIST_W-1:0]       cfg_wr_data,
	input  logic [$clog2(NODE_COUNT)-1:0]     node_index,
	input  logic signed [COORD_WIDTH-1:0]     coord_x,
	input  logic signed [COORD_WIDTH-1:0]     coord_y,
	input  logic [$clog2(NODE_COUNT)-1:0]     left_child,
	input  logic                              left_present,
	input  logic [$clog2(NODE_COUNT)-1:0]     right_child,
	input  logic                              right_present,
	output logic [kdts_pkg::DIST_W-1:0]       min_distance,
	output logic signed [COORD_WIDTH:0]       offset_x,
	output logic signed [COORD_WIDTH:0]       offset_y
);

	localparam int CW      = COORD_WIDTH;
	localparam int IDX_W   = $clog2(NODE_COUNT);
	localparam int LINK_W  = IDX_W + 1;
	localparam int ENTRY_W = 2 * CW + 2 * LINK_W;
	localparam int STEP_W  = $clog2(NODE_COUNT + 1);
	localparam int SUM_W   = CW + 2;
	localparam int CMP_W   = (SUM_W > kdts_pkg::DIST_W) ? SUM_W : kdts_pkg::DIST_W;
	localparam int DW      = kdts_pkg::DIST_W;

	// entry: {left link, right link, y, x}; a link is {present, index}
	logic [ENTRY_W-1:0] mem [NODE_COUNT];
	logic [ENTRY_W-1:0] rdata_q;

	logic [DW-1:0]        bound_q;
	logic                 root_q;
	logic signed [CW-1:0] qx_q;
	logic signed [CW-1:0] qy_q;
	logic [DW-1:0]        best_q;
	logic signed [CW:0]   bx_q;
	logic signed [CW:0]   by_q;
	logic [IDX_W-1:0]     addr_q;
	logic [STEP_W-1:0]    steps_q;
	logic                 odd_q;
	logic signed [CW:0]   dx_q;
	logic signed [CW:0]   dy_q;
	logic [LINK_W-1:0]    link_q;
	logic [SUM_W-1:0]     d_q;

	logic [DW-1:0]        dist_out_q;
	logic signed [CW:0]   offx_out_q;
	logic signed [CW:0]   offy_out_q;

	logic signed [CW-1:0] node_x;
	logic signed [CW-1:0] node_y;
	logic [LINK_W-1:0]    link_left;
	logic [LINK_W-1:0]    link_right;
	logic signed [CW:0]   diff_x;
	logic signed [CW:0]   diff_y;
	logic                 go_left;
	logic [CW:0]          mag_x;
	logic [CW:0]          mag_y;
	logic                 take;
	logic                 write_ok;

	assign node_x     = $signed(rdata_q[CW-1:0]);
	assign node_y     = $signed(rdata_q[2*CW-1:CW]);
	assign link_right = rdata_q[2*CW+LINK_W-1:2*CW];
	assign link_left  = rdata_q[ENTRY_W-1:2*CW+LINK_W];

	assign diff_x  = {qx_q[CW-1], qx_q} - {node_x[CW-1], node_x};
	assign diff_y  = {qy_q[CW-1], qy_q} - {node_y[CW-1], node_y};
	assign go_left = odd_q ? (qy_q <= node_y) : (qx_q <= node_x);

	assign mag_x = dx_q[CW] ? (~dx_q + 1'b1) : dx_q;
	assign mag_y = dy_q[CW] ? (~dy_q + 1'b1) : dy_q;

	assign take     = CMP_W'(d_q) <= CMP_W'(best_q);
	assign write_ok = 32'(node_index) < 32'(NODE_COUNT);

	assign sts.root_present = root_q;
	assign sts.next_valid   = link_q[IDX_W]
		&& (32'(link_q[IDX_W-1:0]) < 32'(NODE_COUNT))
		&& (32'(steps_q) + 32'd1 < 32'(NODE_COUNT));

	assign min_distance = dist_out_q;
	assign offset_x     = offx_out_q;
	assign offset_y     = offy_out_q;

	always_ff @(posedge clk) begin
		if (cmd.write_node && write_ok) begin
			mem[node_index] <= {left_present, left_child, right_present, right_child,
				coord_y, coord_x};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_node) begin
			rdata_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= kdts_pkg::BOUND_RESET;
			root_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				bound_q <= cfg_wr_data;
			end
			if (cmd.write_node && write_ok && (node_index == '0)) begin
				root_q <= 1'b1;
			end else if (cmd.clear_tree) begin
				root_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			qx_q    <= coord_x;
			qy_q    <= coord_y;
			best_q  <= bound_q;
			bx_q    <= '0;
			by_q    <= '0;
			addr_q  <= '0;
			steps_q <= '0;
			odd_q   <= 1'b0;
		end
		if (cmd.eval_diff) begin
			dx_q   <= diff_x;
			dy_q   <= diff_y;
			link_q <= go_left ? link_left : link_right;
		end
		if (cmd.eval_sum) begin
			d_q <= {1'b0, mag_x} + {1'b0, mag_y};
		end
		if (cmd.eval_best) begin
			// later node wins on a tie
			if (take) begin
				best_q <= DW'(d_q);
				bx_q   <= dx_q;
				by_q   <= dy_q;
			end
			addr_q  <= link_q[IDX_W-1:0];
			steps_q <= steps_q + 1'b1;
			odd_q   <= !odd_q;
		end
		if (cmd.load_out) begin
			dist_out_q <= best_q;
			offx_out_q <= bx_q;
			offy_out_q <= by_q;
		end
	end

endmodule

// File: design/kd_tree_greedy_nearest_search.sv
// Top level of the greedy kd-tree nearest-point search.
// A node write, a tree clear and an unused op are each taken in the idle state and give
// no result. A query visits every node on the greedy path (about log2 of NODE_COUNT nodes
// for a balanced tree, at most NODE_COUNT) before its result is registered; each level
// takes a synchronous node-table read, then the coordinate differences and split
// decision, then the Manhattan sum and then the compare against the running best. The
// walk is one node at a time through the single read port of the node table. A finished
// result waits in its own output register, so writes, clears and the next query are
// taken while it is still pending. Entries of the node table are undefined until written;
// a walk must only reach written entries.
module kd_tree_greedy_nearest_search #(
	parameter int NODE_COUNT  = kdts_pkg::NODE_COUNT_DEF,
	parameter int COORD_WIDTH = kdts_pkg::COORD_W_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [kdts_pkg::DIST_W-1:0]       cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [kdts_pkg::OP_W-1:0]         op,
	input  logic [$clog2(NODE_COUNT)-1:0]     node_index,
	input  logic signed [COORD_WIDTH-1:0]     coord_x,
	input  logic signed [COORD_WIDTH-1:0]     coord_y,
	input  logic [$clog2(NODE_COUNT)-1:0]     left_child,
	input  logic                              left_present,
	input  logic [$clog2(NODE_COUNT)-1:0]     right_child,
	input  logic                              right_present,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [kdts_pkg::DIST_W-1:0]       min_distance,
	output logic signed [COORD_WIDTH:0]       offset_x,
	output logic signed [COORD_WIDTH:0]       offset_y
);

	kdts_pkg::cmd_t cmd;
	kdts_pkg::sts_t sts;

	kdts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kdts_dp #(
		.NODE_COUNT  (NODE_COUNT),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.node_index    (node_index),
		.coord_x       (coord_x),
		.coord_y       (coord_y),
		.left_child    (left_child),
		.left_present  (left_present),
		.right_child   (right_child),
		.right_present (right_present),
		.min_distance  (min_distance),
		.offset_x      (offset_x),
		.offset_y      (offset_y)
	);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command in a cycle");

	a_start_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_query |-> (in_valid && in_ready && op == kdts_pkg::OP_QUERY))
		else $error("query started without an accepted query beat");

	a_best_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval_best |-> $past(cmd.eval_sum))
		else $error("best update without a fresh distance");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("loaded result not presented");

endmodule

// File: test/testbench.sv
// Testbench for the greedy kd-tree nearest-point search: random trees, queries and bound changes.
module testbench;

	localparam int NODES = kdts_pkg::NODE_COUNT_DEF;
	localparam logic [kdts_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	class search_scoreboard;
		typedef struct packed {
			logic [kdts_pkg::DIST_W-1:0] min_dist;
			logic signed [24:0]          ox;
			logic signed [24:0]          oy;
		} answer_t;

		logic signed [23:0] point_x [NODES];
		logic signed [23:0] point_y [NODES];
		logic [10:0]        link_l [NODES];
		logic [10:0]        link_r [NODES];
		bit                 root_present;
		logic [kdts_pkg::DIST_W-1:0] bound;
		answer_t            pending_answers [$];
		int                 errors, queries, hits, writes, clears;

		function new();
			bound = kdts_pkg::BOUND_RESET;
			root_present = 1'b0;
		endfunction

		// walk from the root with no backtracking, keep the closest node within the bound
		function answer_t greedy_search(logic signed [23:0] qx, logic signed [23:0] qy);
			answer_t     a;
			longint      best, bx, by, dx, dy, d;
			logic [10:0] link;
			bit          walking, odd, go_left, found;
			int          cur, visits;
			best = bound;
			bx = 0;
			by = 0;
			walking = root_present;
			cur = 0;
			odd = 1'b0;
			visits = 0;
			found = 1'b0;
			while (walking && visits < NODES) begin
				dx = longint'(qx) - longint'(point_x[cur]);
				dy = longint'(qy) - longint'(point_y[cur]);
				d = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
				// ties go to the deeper node
				if (d <= best) begin
					best = d;
					bx = dx;
					by = dy;
					found = 1'b1;
				end
				go_left = odd ? (qy <= point_y[cur]) : (qx <= point_x[cur]);
				link = go_left ? link_l[cur] : link_r[cur];
				walking = link[10];
				cur = link[9:0];
				odd = !odd;
				visits++;
			end
			if (found)
				hits++;
			a.min_dist = best[kdts_pkg::DIST_W-1:0];
			a.ox = bx[24:0];
			a.oy = by[24:0];
			return a;
		endfunction

		function void take_item(logic [kdts_pkg::OP_W-1:0] op, logic [9:0] idx,
				logic signed [23:0] x, logic signed [23:0] y,
				logic [9:0] lc, logic lp, logic [9:0] rc, logic rp);
			case (op)
				kdts_pkg::OP_WRITE: begin
					point_x[idx] = x;
					point_y[idx] = y;
					link_l[idx] = {lp, lc};
					link_r[idx] = {rp, rc};
					if (idx == 0)
						root_present = 1'b1;
					writes++;
				end
				kdts_pkg::OP_CLEAR: begin
					root_present = 1'b0;
					clears++;
				end
				kdts_pkg::OP_QUERY: begin
					queries++;
					pending_answers.push_back(greedy_search(x, y));
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [kdts_pkg::DIST_W-1:0] min_dist,
				logic signed [24:0] ox, logic signed [24:0] oy);
			answer_t want;
			if (pending_answers.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: dist=%0d dx=%0d dy=%0d", min_dist, ox, oy);
				return;
			end
			want = pending_answers.pop_front();
			if (min_dist !== want.min_dist || ox !== want.ox || oy !== want.oy) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected dist=%0d dx=%0d dy=%0d, got dist=%0d dx=%0d dy=%0d",
						want.min_dist, want.ox, want.oy, min_dist, ox, oy);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [kdts_pkg::DIST_W-1:0] cfg_wr_data;
	logic                in_valid;
	logic                in_ready;
	logic [kdts_pkg::OP_W-1:0]   op;
	logic [9:0]          node_index;
	logic signed [23:0]  coord_x;
	logic signed [23:0]  coord_y;
	logic [9:0]          left_child;
	logic                left_present;
	logic [9:0]          right_child;
	logic                right_present;
	logic                out_valid;
	logic                out_ready;
	logic [kdts_pkg::DIST_W-1:0] min_distance;
	logic signed [24:0]  offset_x;
	logic signed [24:0]  offset_y;

	search_scoreboard sb = new();
	bit               calm = 1'b0;
	int               bound_settings = 0;
	logic signed [23:0] pt_x [16];
	logic signed [23:0] pt_y [16];
	int               n_pts = 0;

	kd_tree_greedy_nearest_search dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.node_index   (node_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.left_child   (left_child),
		.left_present (left_present),
		.right_child  (right_child),
		.right_present(right_present),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.min_distance (min_distance),
		.offset_x     (offset_x),
		.offset_y     (offset_y)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(min_distance, offset_x, offset_y);
	end

	// result side: stall in random bursts except in the final phase
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(0, 10)) @(negedge clk);
				@(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	function automatic logic signed [23:0] to_coord(longint v);
		if (v > 8388607)
			v = 8388607;
		if (v < -8388608)
			v = -8388608;
		return v[23:0];
	endfunction

	function automatic longint jitter(int level);
		case (level)
			0: return 0;
			1: return longint'(int'($urandom_range(0, 512))) - 256;
			2: return longint'(int'($urandom_range(0, 200000))) - 100000;
			default: return longint'(int'($urandom_range(0, 2000000))) - 1000000;
		endcase
	endfunction

	task automatic send_item(logic [kdts_pkg::OP_W-1:0] o, logic [9:0] idx,
			logic signed [23:0] x, logic signed [23:0] y, logic [9:0] lc, logic lp,
			logic [9:0] rc, logic rp);
		if (!calm && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(0, 10)) @(negedge clk);
		end
		@(negedge clk);
		op = o;
		node_index = idx;
		coord_x = x;
		coord_y = y;
		left_child = lc;
		left_present = lp;
		right_child = rc;
		right_present = rp;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.take_item(o, idx, x, y, lc, lp, rc, rp);
	endtask

	task automatic query(logic signed [23:0] x, logic signed [23:0] y);
		send_item(kdts_pkg::OP_QUERY, 10'($urandom), x, y, 10'($urandom), 1'($urandom),
			10'($urandom), 1'($urandom));
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending_answers.size() != 0) @(posedge clk);
	endtask

	task automatic load_bound(logic [kdts_pkg::DIST_W-1:0] v);
		wait_drain();
		// let a trailing write or clear settle
		repeat (4) @(negedge clk);
		cfg_wr_data = v;
		cfg_wr_en = 1'b1;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		sb.bound = v;
		bound_settings++;
	endtask

	// write a fresh tree bottom-up; children only point at nodes already written in this pass,
	// so the walk never meets an unwritten entry and never loops
	task automatic build_tree(int count);
		int                 idx [10];
		int                 k, j;
		bit                 dup;
		longint             cx, cy;
		int                 spread;
		logic signed [23:0] x, y;
		logic [9:0]         lc, rc;
		logic               lp, rp;
		cx = longint'(24'sh0) + (($urandom_range(0, 1) == 0) ? longint'($signed(24'($urandom)))
			: jitter(2));
		cy = (($urandom_range(0, 1) == 0) ? longint'($signed(24'($urandom))) : jitter(2));
		spread = $urandom_range(1, 3);
		for (k = 0; k < count - 1; k++) begin
			do begin
				idx[k] = $urandom_range(1, NODES - 1);
				dup = 1'b0;
				for (j = 0; j < k; j++)
					if (idx[j] == idx[k])
						dup = 1'b1;
			end while (dup);
		end
		idx[count - 1] = 0;
		for (k = 0; k < count; k++) begin
			x = (spread == 3 && $urandom_range(0, 3) == 0) ? 24'($urandom)
				: to_coord(cx + jitter(spread));
			y = to_coord(cy + jitter(spread));
			lp = (k > 0) && ($urandom_range(0, 3) != 0);
			rp = (k > 0) && ($urandom_range(0, 3) != 0);
			lc = lp ? 10'(idx[$urandom_range(0, k - 1)]) : 10'($urandom);
			rc = rp ? 10'(idx[$urandom_range(0, k - 1)]) : 10'($urandom);
			send_item(kdts_pkg::OP_WRITE, 10'(idx[k]), x, y, lc, lp, rc, rp);
			pt_x[k] = x;
			pt_y[k] = y;
		end
		n_pts = count;
	endtask

	task automatic random_query();
		int j, lvl;
		if (n_pts > 0 && $urandom_range(0, 2) != 0) begin
			j = $urandom_range(0, n_pts - 1);
			lvl = $urandom_range(0, 2);
			query(to_coord(longint'(pt_x[j]) + jitter(lvl)),
				to_coord(longint'(pt_y[j]) + jitter(lvl)));
		end else begin
			query(24'($urandom), 24'($urandom));
		end
	endtask

	function automatic logic signed [23:0] extreme_coord();
		case ($urandom_range(0, 2))
			0: return 24'sh800000;
			1: return 24'sh7FFFFF;
			default: return 24'sh000000;
		endcase
	endfunction

	initial begin
		int                 p, done, pick, k;
		logic [kdts_pkg::DIST_W-1:0] bounds [6];
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		op = kdts_pkg::OP_WRITE;
		node_index = '0;
		coord_x = '0;
		coord_y = '0;
		left_child = '0;
		left_present = 1'b0;
		right_child = '0;
		right_present = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty tree
		query(24'sd0, 24'sd0);
		send_item(kdts_pkg::OP_WRITE, 10'd5, 24'sh7FFFFF, 24'sh800000, 10'h3FF, 1'b0, 10'd0,
			1'b0);
		send_item(kdts_pkg::OP_WRITE, 10'd3, 24'sd0, 24'sd0, 10'd0, 1'b0, 10'h3FF, 1'b0);
		send_item(kdts_pkg::OP_WRITE, 10'd1023, 24'sd256, -24'sd256, 10'h3FF, 1'b0, 10'h3FF,
			1'b0);
		send_item(kdts_pkg::OP_WRITE, 10'd0, 24'sd100, 24'sd100, 10'd3, 1'b1, 10'd5, 1'b1);
		query(24'sd100, 24'sd100);
		// nothing within the bound
		query(24'sh800000, 24'sh7FFFFF);
		// equal distance at root and child: the child wins
		query(24'sd50, 24'sd50);
		query(24'sh7FFFFF, 24'sh800000);
		// query equal to the split coordinate goes left
		query(24'sd100, 24'sd0);
		send_item(OP_UNUSED, 10'h3FF, 24'sd1, 24'sd1, 10'h3FF, 1'b1, 10'h3FF, 1'b1);
		send_item(kdts_pkg::OP_CLEAR, 10'd0, 24'sd0, 24'sd0, 10'd0, 1'b0, 10'd0, 1'b0);
		query(24'sd100, 24'sd100);
		// entries survive a clear; rewriting the root brings the tree back
		send_item(kdts_pkg::OP_WRITE, 10'd0, 24'sd100, 24'sd100, 10'd1023, 1'b1, 10'd3, 1'b1);
		query(24'sd300, -24'sd300);
		query(24'sd0, 24'sd0);
		// root linked to itself: the walk stops on the visit limit
		send_item(kdts_pkg::OP_WRITE, 10'd0, -24'sd50, 24'sd75, 10'd0, 1'b1, 10'd0, 1'b1);
		query(24'sd10, 24'sd10);
		send_item(kdts_pkg::OP_WRITE, 10'd0, 24'sd0, 24'sd0, 10'd0, 1'b0, 10'd0, 1'b0);
		query(24'sh800000, 24'sh800000);

		bounds[0] = '0;
		bounds[1] = 24'hFFFFFF;
		bounds[2] = $urandom_range(1000, 200000);
		bounds[3] = kdts_pkg::BOUND_RESET;
		bounds[4] = 24'($urandom);
		bounds[5] = 24'hFFFFFF;
		for (p = 0; p < 6; p++) begin
			load_bound(bounds[p]);
			if (p == 5)
				calm = 1'b1;
			done = 0;
			while (done < 72) begin
				pick = $urandom_range(0, 99);
				if (pick < 28) begin
					k = ($urandom_range(0, 9) == 0) ? 10 : $urandom_range(1, 6);
					build_tree(k);
					done += k;
					repeat ($urandom_range(1, 4)) begin
						random_query();
						done++;
					end
				end else if (pick < 75) begin
					random_query();
					done++;
				end else if (pick < 85) begin
					// childless overwrite with random payload
					send_item(kdts_pkg::OP_WRITE, 10'($urandom), 24'($urandom), 24'($urandom),
						10'($urandom), 1'b0, 10'($urandom), 1'b0);
					done++;
				end else if (pick < 90) begin
					send_item(kdts_pkg::OP_CLEAR, 10'($urandom), 24'($urandom), 24'($urandom),
						10'($urandom), 1'($urandom), 10'($urandom), 1'($urandom));
					done++;
				end else if (pick < 93) begin
					send_item(OP_UNUSED, 10'($urandom), 24'($urandom), 24'($urandom),
						10'($urandom), 1'($urandom), 10'($urandom), 1'($urandom));
				end else if (pick < 96) begin
					if (!calm)
						wait_drain();
				end else begin
					query(extreme_coord(), extreme_coord());
					done++;
				end
			end
		end

		wait_drain();
		repeat (60) @(posedge clk);
		$display("covered %0d queries (%0d found a node in bound), %0d node writes, %0d clears",
			sb.queries, sb.hits, sb.writes, sb.clears);
		$display("bound register loaded %0d times, zero and full scale included; %0d mismatches",
			bound_settings, sb.errors);
		if (sb.errors == 0 && sb.pending_answers.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#(8 * 600000);
		$display("timeout with %0d results outstanding", sb.pending_answers.size());
		$display("status: fail");
		$finish;
	end

endmodule
